// ----- src/length_prefixed_deframer_macros.svh -----
// Assertion macros for the deframer's checking code.
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define LPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lpd_pkg.sv -----
// Shared types and constants of the length-prefixed deframer.
package lpd_pkg;

  localparam int BYTE_W          = 8;
  localparam int MAX_FIELD_BYTES = 4;
  localparam int FIELD_W         = 3;
  localparam int TOTAL_W         = 4;
  localparam int PROT_W          = 32;
  localparam int LEN_ACC_W       = 32;
  localparam int FRAME_LEN_W     = 24;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PROTOCOL_BYTES  = 3'd0;
  localparam cfg_idx_t REG_LENGTH_BYTES    = 3'd1;
  localparam cfg_idx_t REG_LITTLE_ENDIAN   = 3'd2;
  localparam cfg_idx_t REG_LENGTH_INCL_HDR = 3'd3;
  localparam cfg_idx_t REG_USE_CHECKSUM    = 3'd4;
  localparam cfg_idx_t REG_MAX_FRAME_LEN   = 3'd5;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_LEN = 2'd2
  } kind_t;

  typedef struct packed {
    logic [FIELD_W-1:0]     protocol_bytes;
    logic [FIELD_W-1:0]     length_bytes;
    logic                   little_endian;
    logic                   length_includes_header;
    logic                   use_checksum;
    logic [FRAME_LEN_W-1:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_t             out_kind;
    logic [BYTE_W-1:0] data_byte;
    logic [PROT_W-1:0] protocol;
    logic              last;
    logic              checksum_ok;
  } res_t;

endpackage

// ----- src/lpd_if.sv -----
// Valid/ready channel interfaces for received words and parsed result words.
interface lpd_in_if;
  import lpd_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface lpd_out_if;
  import lpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic [BYTE_W-1:0] data_byte;
  logic [PROT_W-1:0] protocol;
  logic              last;
  logic              checksum_ok;

  modport source (output valid, out_kind, data_byte, protocol, last, checksum_ok, input ready);
  modport sink   (input valid, out_kind, data_byte, protocol, last, checksum_ok, output ready);
endinterface

// ----- src/lpd_cfg.sv -----
// Configuration register file of the deframer.
module lpd_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  lpd_pkg::cfg_idx_t  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output lpd_pkg::cfg_t      cfg
);
  import lpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_bytes         <= FIELD_W'(2);
      cfg.length_bytes           <= FIELD_W'(4);
      cfg.little_endian          <= 1'b0;
      cfg.length_includes_header <= 1'b1;
      cfg.use_checksum           <= 1'b1;
      cfg.max_frame_length       <= FRAME_LEN_W'(65535);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROTOCOL_BYTES:  cfg.protocol_bytes         <= cfg_data[FIELD_W-1:0];
        REG_LENGTH_BYTES:    cfg.length_bytes           <= cfg_data[FIELD_W-1:0];
        REG_LITTLE_ENDIAN:   cfg.little_endian          <= cfg_data[0];
        REG_LENGTH_INCL_HDR: cfg.length_includes_header <= cfg_data[0];
        REG_USE_CHECKSUM:    cfg.use_checksum           <= cfg_data[0];
        REG_MAX_FRAME_LEN:   cfg.max_frame_length       <= cfg_data[FRAME_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/lpd_in_stage.sv -----
// Input register that holds one received word until the parser takes it.
module lpd_in_stage (
  input  logic           clk,
  input  logic           rst,
  lpd_in_if.sink         rx,
  input  logic           take,
  output logic           in_valid,
  output lpd_pkg::item_t item
);
  import lpd_pkg::*;

  assign rx.ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.op      <= rx.op;
      item.rx_byte <= rx.rx_byte;
    end
  end

endmodule

// ----- src/lpd_parser.sv -----
// Frame parser: header collection, length checks, payload and checksum tracking.
module lpd_parser (
  input  logic           clk,
  input  logic           rst,
  input  lpd_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  lpd_pkg::item_t item,
  input  logic           out_ready,
  output logic           take,
  output logic           res_valid,
  output lpd_pkg::res_t  res
);
  import lpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  phase_t                  phase, phase_next;
  logic [FIELD_W-1:0]      header_count, header_count_next;
  logic [PROT_W-1:0]       protocol_acc, protocol_acc_next;
  logic [LEN_ACC_W-1:0]    length_acc, length_acc_next;
  logic                    length_high, length_high_next;
  logic [FRAME_LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [BYTE_W-1:0]       xor_acc, xor_acc_next;
  logic [BYTE_W-1:0]       held_byte, held_byte_next;
  logic                    held_valid, held_valid_next;

  logic [FIELD_W-1:0]      pw, lw, len_pos;
  logic [TOTAL_W-1:0]      total, count_inc;
  logic                    first, in_prot, in_len, hdr_done;
  logic [PROT_W-1:0]       prot_base, prot_new;
  logic [LEN_ACC_W-1:0]    len_base, len_new;
  logic                    high_new, len_over, len_small;
  logic [FRAME_LEN_W-1:0]  rem;
  logic                    rem_zero, more_left;
  logic [BYTE_W-1:0]       b;

  assign take = in_valid && out_ready;
  assign b    = item.rx_byte;

  // Field widths with out-of-range settings clamped.
  assign pw = (cfg.protocol_bytes > FIELD_W'(MAX_FIELD_BYTES)) ?
              FIELD_W'(MAX_FIELD_BYTES) : cfg.protocol_bytes;
  assign lw = (cfg.length_bytes == '0) ? FIELD_W'(1) :
              (cfg.length_bytes > FIELD_W'(MAX_FIELD_BYTES)) ?
              FIELD_W'(MAX_FIELD_BYTES) : cfg.length_bytes;
  assign total     = {1'b0, pw} + {1'b0, lw};
  assign count_inc = {1'b0, header_count} + TOTAL_W'(1);
  assign hdr_done  = (count_inc >= total);

  assign first   = (header_count == '0);
  assign in_prot = (header_count < pw);
  assign len_pos = header_count - pw;
  assign in_len  = !in_prot && (len_pos < lw);

  assign prot_base = first ? '0 : protocol_acc;
  assign len_base  = first ? '0 : length_acc;

  always_comb begin
    prot_new = prot_base;
    len_new  = len_base;
    high_new = first ? 1'b0 : length_high;
    if (in_prot) begin
      if (cfg.little_endian) begin
        prot_new = prot_base | (PROT_W'(b) << {header_count[1:0], 3'b000});
      end else begin
        prot_new = {prot_base[PROT_W-BYTE_W-1:0], b};
      end
    end else if (in_len) begin
      if (cfg.little_endian) begin
        len_new = len_base | (LEN_ACC_W'(b) << {len_pos[1:0], 3'b000});
      end else begin
        // Bits shifted out the top still make the length too large.
        len_new  = {len_base[LEN_ACC_W-BYTE_W-1:0], b};
        high_new = high_new || (len_base[LEN_ACC_W-1:LEN_ACC_W-BYTE_W] != '0);
      end
    end
  end

  assign len_over  = high_new ||
                     (len_new > {{(LEN_ACC_W-FRAME_LEN_W){1'b0}}, cfg.max_frame_length});
  assign len_small = cfg.length_includes_header && (len_new < LEN_ACC_W'(total));
  assign rem       = cfg.length_includes_header ?
                     len_new[FRAME_LEN_W-1:0] - FRAME_LEN_W'(total) :
                     len_new[FRAME_LEN_W-1:0];
  assign rem_zero  = (rem == '0);
  assign more_left = (bytes_left > FRAME_LEN_W'(1));

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    protocol_acc_next = protocol_acc;
    length_acc_next   = length_acc;
    length_high_next  = length_high;
    bytes_left_next   = bytes_left;
    xor_acc_next      = xor_acc;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    res_valid         = 1'b0;
    res.out_kind      = KIND_DATA;
    res.data_byte     = '0;
    res.protocol      = protocol_acc;
    res.last          = 1'b0;
    res.checksum_ok   = 1'b0;

    if (take) begin
      if (item.op == OP_RESTART) begin
        phase_next        = PH_HUNT;
        header_count_next = '0;
        bytes_left_next   = '0;
        xor_acc_next      = '0;
        held_valid_next   = 1'b0;
      end else if (phase == PH_PAYLOAD) begin
        if (cfg.use_checksum) begin
          if (more_left) begin
            bytes_left_next = bytes_left - FRAME_LEN_W'(1);
            xor_acc_next    = xor_acc ^ b;
            held_byte_next  = b;
            held_valid_next = 1'b1;
            res_valid       = held_valid;
            res.data_byte   = held_byte;
          end else begin
            // Checksum byte: release the held byte as the last one.
            phase_next      = PH_HUNT;
            bytes_left_next = '0;
            xor_acc_next    = '0;
            held_valid_next = 1'b0;
            res_valid       = 1'b1;
            res.out_kind    = held_valid ? KIND_DATA : KIND_EMPTY;
            res.data_byte   = held_valid ? held_byte : '0;
            res.last        = 1'b1;
            res.checksum_ok = (xor_acc == b);
          end
        end else begin
          held_valid_next = 1'b0;
          res_valid       = 1'b1;
          res.data_byte   = b;
          if (more_left) begin
            bytes_left_next = bytes_left - FRAME_LEN_W'(1);
          end else begin
            phase_next      = PH_HUNT;
            bytes_left_next = '0;
            xor_acc_next    = '0;
            res.last        = 1'b1;
            res.checksum_ok = 1'b1;
          end
        end
      end else begin
        protocol_acc_next = prot_new;
        length_acc_next   = len_new;
        length_high_next  = high_new;
        res.protocol      = prot_new;
        if (!hdr_done) begin
          header_count_next = count_inc[FIELD_W-1:0];
        end else begin
          header_count_next = '0;
          if (len_over || len_small || (cfg.use_checksum && rem_zero)) begin
            res_valid    = 1'b1;
            res.out_kind = KIND_BAD_LEN;
          end else if (rem_zero) begin
            res_valid       = 1'b1;
            res.out_kind    = KIND_EMPTY;
            res.last        = 1'b1;
            res.checksum_ok = 1'b1;
          end else begin
            phase_next      = PH_PAYLOAD;
            bytes_left_next = rem;
            xor_acc_next    = '0;
            held_valid_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      header_count <= '0;
      bytes_left   <= '0;
      xor_acc      <= '0;
      held_valid   <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      bytes_left   <= bytes_left_next;
      xor_acc      <= xor_acc_next;
      held_valid   <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    protocol_acc <= protocol_acc_next;
    length_acc   <= length_acc_next;
    length_high  <= length_high_next;
    held_byte    <= held_byte_next;
  end

endmodule

// ----- src/lpd_out_stage.sv -----
// Result register that decouples the parser from a stalling receiver.
module lpd_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  lpd_pkg::res_t res,
  output logic          out_ready,
  lpd_out_if.source     tx
);
  import lpd_pkg::*;

  res_t held;

  assign out_ready = !tx.valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (out_ready) begin
      tx.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res_valid) begin
      held <= res;
    end
  end

  assign tx.out_kind    = held.out_kind;
  assign tx.data_byte   = held.data_byte;
  assign tx.protocol    = held.protocol;
  assign tx.last        = held.last;
  assign tx.checksum_ok = held.checksum_ok;

endmodule

// ----- src/length_prefixed_deframer.sv -----
// Top level of the length-prefixed deframer with XOR checksum check.
//
// The rx channel carries one word per handshake: op selects a received byte
// or a link restart, which drops any partial header or frame. The tx channel
// carries parsed result words: payload bytes tagged with the frame's protocol,
// an empty-frame marker, or a bad-length error. The last payload word of a
// frame has last set and checksum_ok tells whether the trailing XOR matched.
// With the checksum enabled, each payload byte leaves one received word late,
// since it is only known to be payload once the next byte arrives.
//
// Throughput is one word per cycle while tx does not stall. A word is
// registered in the input register at acceptance and parsed from there into
// the result register, which drives tx.
// When tx stalls, the result register holds and the input register fills;
// rx.ready then drops until the receiver takes the waiting result.
//
// Reset (rst, synchronous) empties both registers, puts the parser into
// header hunt and loads the configuration defaults. The configuration port
// is a plain write port: cfg_we with cfg_index and cfg_data, no read-back.
module length_prefixed_deframer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  lpd_pkg::cfg_idx_t              cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data,
  lpd_in_if.sink                         rx,
  lpd_out_if.source                      tx
);
  import lpd_pkg::*;

`include "length_prefixed_deframer_macros.svh"

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  logic  take;
  logic  out_ready;
  logic  res_valid;
  res_t  res;

  // Live configuration; every word is parsed with the current values.
  lpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: refills in the same cycle that the parser takes its word.
  lpd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .take     (take),
    .in_valid (in_valid),
    .item     (in_item)
  );

  // The parser advances only when the result register can take its output,
  // so no result is ever dropped.
  lpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .item      (in_item),
    .out_ready (out_ready),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .tx        (tx)
  );

  `LPD_ASSERT_NOW(a_result_needs_word, res_valid, (in_valid && out_ready), "result without a word taken")
  `LPD_ASSERT_NEXT(a_result_reaches_tx, res_valid, tx.valid, "parsed result did not reach tx")
  `LPD_ASSERT_NOW(a_restart_silent, (take && in_item.op == OP_RESTART), !res_valid, "restart produced a result")
  `LPD_ASSERT_NOW(a_error_shape, (res_valid && res.out_kind == KIND_BAD_LEN), (!res.last && !res.checksum_ok && res.data_byte == '0), "malformed error result")

endmodule
